@@ src/nnt_pkg.sv @@
package nnt_pkg;

    localparam int MAX_OBJECTS = 32;
    localparam int IDX_W       = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
    localparam int CNT_W       = $clog2(MAX_OBJECTS + 1);
    localparam int ADDR_W      = IDX_W + 1;
    localparam int COORD_W     = 16;
    localparam int ID_W        = 16;
    localparam int TOL_W       = 16;
    localparam int FRAME_W     = 6;
    localparam int SQ_W        = 2 * COORD_W;
    localparam int DIST_W      = SQ_W + 1;
    localparam int WORD_W      = 2 * COORD_W + ID_W;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(50);

    // register word index on the apb port
    localparam logic REG_MATCH_TOL = 1'b0;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_DRAIN,
        S_DECIDE
    } t_state;

    typedef struct packed {
        logic start;
        logic issue;
    } t_scan_req;

    typedef struct packed {
        logic            busy;
        logic            hit;
        logic [ID_W-1:0] best_id;
    } t_scan_res;

endpackage

@@ src/nnt_table_ram.sv @@
module nnt_table_ram (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [nnt_pkg::ADDR_W-1:0]  i_waddr,
    input  logic [nnt_pkg::WORD_W-1:0]  i_wdata,
    input  logic [nnt_pkg::ADDR_W-1:0]  i_raddr,
    output logic [nnt_pkg::WORD_W-1:0]  o_rdata
);
    import nnt_pkg::*;

    localparam int DEPTH = 2 ** ADDR_W;

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/nnt_dist_unit.sv @@
module nnt_dist_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  nnt_pkg::t_scan_req                  i_req,
    input  logic signed [nnt_pkg::COORD_W-1:0]  i_x,
    input  logic signed [nnt_pkg::COORD_W-1:0]  i_y,
    input  logic [nnt_pkg::TOL_W-1:0]           i_tol,
    input  logic [nnt_pkg::WORD_W-1:0]          i_rdata,
    output nnt_pkg::t_scan_res                  o_res
);
    import nnt_pkg::*;

    logic                r_v1;
    logic                r_v2;
    logic [SQ_W-1:0]     r_sq_x;
    logic [SQ_W-1:0]     r_sq_y;
    logic [ID_W-1:0]     r_id2;
    logic [DIST_W-1:0]   r_best_d;
    logic [ID_W-1:0]     r_best_id;
    logic [SQ_W-1:0]     r_tol_sq;

    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic [ID_W-1:0]           pid;
    logic signed [COORD_W:0]   dx;
    logic signed [COORD_W:0]   dy;
    logic [COORD_W:0]          ax;
    logic [COORD_W:0]          ay;
    logic [DIST_W-1:0]         d_sum;

    assign px  = i_rdata[COORD_W-1:0];
    assign py  = i_rdata[2*COORD_W-1:COORD_W];
    assign pid = i_rdata[WORD_W-1:2*COORD_W];

    always_comb begin
        dx    = {i_x[COORD_W-1], i_x} - {px[COORD_W-1], px};
        dy    = {i_y[COORD_W-1], i_y} - {py[COORD_W-1], py};
        ax    = dx[COORD_W] ? (COORD_W+1)'(-dx) : dx;
        ay    = dy[COORD_W] ? (COORD_W+1)'(-dy) : dy;
        d_sum = {1'b0, r_sq_x} + {1'b0, r_sq_y};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_req.issue;
            r_v2 <= r_v1;
        end
    end

    // squares of the coordinate differences, one stored entry per cycle
    always_ff @(posedge i_clk) begin
        r_sq_x   <= ax[COORD_W-1:0] * ax[COORD_W-1:0];
        r_sq_y   <= ay[COORD_W-1:0] * ay[COORD_W-1:0];
        r_id2    <= pid;
        r_tol_sq <= i_tol * i_tol;
    end

    // strict compare keeps the lowest index on ties
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_best_d <= '1;
        end else if (r_v2 && (d_sum < r_best_d)) begin
            r_best_d  <= d_sum;
            r_best_id <= r_id2;
        end
    end

    assign o_res.busy    = r_v1 | r_v2;
    assign o_res.hit     = r_best_d < {1'b0, r_tol_sq};
    assign o_res.best_id = r_best_id;

endmodule

@@ src/nearest_neighbor_id_tracker_unit.sv @@
// Nearest-neighbor id tracker. Each center transfer is compared against every
// center stored for the previous frame, one stored center per clock through a
// shared squared-distance unit, and gets the nearest old id if that distance is
// below match_tolerance, else a fresh 16-bit id; a center that finds the
// current table full gets id 0 and the overflow flag. An end-of-frame transfer
// swaps the current and previous tables. The previous table holds at most 32
// centers. An end of frame, or a center that finds the previous table empty or
// the current one full, skips the scan over the single-read-port table memory.
// The block takes one item at a time; a finished result waits in an output
// register. match_tolerance sits at apb address 0.
module nearest_neighbor_id_tracker_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_action,
    input  logic signed [nnt_pkg::COORD_W-1:0] i_center_x,
    input  logic signed [nnt_pkg::COORD_W-1:0] i_center_y,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [nnt_pkg::ID_W-1:0]           o_object_id,
    output logic                               o_matched,
    output logic                               o_overflow,
    output logic [nnt_pkg::FRAME_W-1:0]        o_frame_count,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [nnt_pkg::PADDR_W-1:0]        paddr,
    input  logic [nnt_pkg::PDATA_W-1:0]        pwdata,
    output logic [nnt_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready
);
    import nnt_pkg::*;

    t_state r_state;
    t_state n_state;

    logic                      r_action;
    logic signed [COORD_W-1:0] r_x;
    logic signed [COORD_W-1:0] r_y;
    logic [TOL_W-1:0]          r_tol;
    logic                      r_cur_bank;
    logic [CNT_W-1:0]          r_cur_count;
    logic [CNT_W-1:0]          r_prev_count;
    logic [IDX_W-1:0]          r_scan;
    logic [ID_W-1:0]           r_fresh_id;

    logic                      r_out_valid;
    logic [ID_W-1:0]           r_out_id;
    logic                      r_out_matched;
    logic                      r_out_overflow;
    logic [FRAME_W-1:0]        r_out_frame;

    logic        accept;
    logic        fire;
    logic        scan_last;
    logic        skip_scan;
    logic        cur_full;
    logic        cfg_write;
    t_scan_req   req;
    t_scan_res   res;
    logic        we;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic [WORD_W-1:0] wdata;
    logic [WORD_W-1:0] rdata;
    logic [ID_W-1:0]   sel_id;

    assign cur_full  = r_cur_count >= CNT_W'(MAX_OBJECTS);
    assign scan_last = (CNT_W'(r_scan) + CNT_W'(1)) == r_prev_count;
    assign skip_scan = i_action || (r_prev_count == '0) || cur_full;
    assign cfg_write = psel && penable && pwrite && pready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = skip_scan ? S_DECIDE : S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!res.busy) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (fire) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready = 1'b0;
        req.start  = 1'b0;
        req.issue  = 1'b0;
        fire       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                req.start  = i_in_valid;
            end
            S_SEARCH: begin
                req.issue = 1'b1;
            end
            S_DRAIN: begin
            end
            S_DECIDE: begin
                fire = !r_out_valid || i_out_ready;
            end
            default: begin
            end
        endcase
    end

    assign accept = i_in_valid && o_in_ready;

    assign sel_id = res.hit ? res.best_id : r_fresh_id;
    assign we     = fire && !r_action && !cur_full;
    assign waddr  = {r_cur_bank, r_cur_count[IDX_W-1:0]};
    assign wdata  = {sel_id, r_y, r_x};
    assign raddr  = {~r_cur_bank, r_scan};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action <= i_action;
            r_x      <= i_center_x;
            r_y      <= i_center_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_scan <= '0;
        end else if (req.issue) begin
            r_scan <= r_scan + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (cfg_write && (paddr[PADDR_W-1] == REG_MATCH_TOL)) begin
            r_tol <= pwdata[TOL_W-1:0];
        end
    end

    // frame tables live in two banks; end of frame just swaps them
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_bank   <= 1'b0;
            r_cur_count  <= '0;
            r_prev_count <= '0;
            r_fresh_id   <= '0;
        end else if (fire) begin
            if (r_action) begin
                r_cur_bank   <= ~r_cur_bank;
                r_prev_count <= r_cur_count;
                r_cur_count  <= '0;
            end else if (!cur_full) begin
                r_cur_count <= r_cur_count + CNT_W'(1);
                if (!res.hit) begin
                    r_fresh_id <= r_fresh_id + ID_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            if (r_action) begin
                r_out_id       <= '0;
                r_out_matched  <= 1'b0;
                r_out_overflow <= 1'b0;
                r_out_frame    <= FRAME_W'(r_cur_count);
            end else if (cur_full) begin
                r_out_id       <= '0;
                r_out_matched  <= 1'b0;
                r_out_overflow <= 1'b1;
                r_out_frame    <= FRAME_W'(r_cur_count);
            end else begin
                r_out_id       <= sel_id;
                r_out_matched  <= res.hit;
                r_out_overflow <= 1'b0;
                r_out_frame    <= FRAME_W'(r_cur_count + CNT_W'(1));
            end
        end
    end

    nnt_table_ram u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    nnt_dist_unit u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .i_x     (r_x),
        .i_y     (r_y),
        .i_tol   (r_tol),
        .i_rdata (rdata),
        .o_res   (res)
    );

    assign o_out_valid   = r_out_valid;
    assign o_object_id   = r_out_id;
    assign o_matched     = r_out_matched;
    assign o_overflow    = r_out_overflow;
    assign o_frame_count = r_out_frame;

    assign pready = 1'b1;
    assign prdata = (paddr[PADDR_W-1] == REG_MATCH_TOL) ? PDATA_W'(r_tol) : '0;

endmodule
